FILE: rtl/rsnh_pkg.sv
// Shared types and constants for the ray-sphere nearest-hit block.
`timescale 1ns / 1ps
`default_nettype none
package rsnh_pkg;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPHERE_RADIUS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE     = 3'd7;

   localparam logic signed [17:0] DIR_Z_RESET     = 18'sd65536;
   localparam logic [23:0]        RADIUS_RESET    = 24'd1966;
   localparam logic [30:0]        MAX_RANGE_RESET = 31'd6553600;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic signed [17:0] dir_z;
      logic [23:0]        sphere_radius;
      logic [30:0]        max_range;
   } cfg_type;

   typedef struct packed {
      logic signed [32:0] off_x;
      logic signed [32:0] off_y;
      logic signed [32:0] off_z;
      logic [31:0]        cand_id;
      logic               test;
      logic               last;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT_X,
      ST_DOT_Y,
      ST_DOT_Z,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_RAD_SQ,
      ST_B_SQ,
      ST_ROOT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/rsnh_front.sv
// Front end: accepts candidates, forms the origin offsets and queues them.
`timescale 1ns / 1ps
`default_nettype none
module rsnh_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsnh_pkg::cfg_type   cfg,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [31:0]  req_center_x,
   input  wire logic signed [31:0]  req_center_y,
   input  wire logic signed [31:0]  req_center_z,
   input  wire logic [31:0]         req_entity_id,
   input  wire logic                req_is_remote,
   input  wire logic                req_last,
   output logic                     q_valid,
   output rsnh_pkg::entry_type      q_entry,
   input  wire logic                q_pop
);
   import rsnh_pkg::*;

   entry_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   entry_type                new_entry;
   logic                     push;
   logic                     pop;

   always_comb begin
      new_entry.off_x   = 33'(cfg.origin_x) - 33'(req_center_x);
      new_entry.off_y   = 33'(cfg.origin_y) - 33'(req_center_y);
      new_entry.off_z   = 33'(cfg.origin_z) - 33'(req_center_z);
      new_entry.cand_id = req_entity_id;
      new_entry.test    = req_is_remote;
      new_entry.last    = req_last;
   end

   assign req_stall = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/rsnh_mul.sv
// Iterative sign-magnitude multiplier that retires eight multiplier bits a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsnh_mul #(
   parameter int M_W = 38
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [M_W-1:0]     a_mag,
   input  wire logic [M_W-1:0]     b_mag,
   input  wire logic               neg,
   output logic                    done,
   output logic signed [2*M_W:0]   prod
);
   import rsnh_pkg::*;

   localparam int P_W    = 2 * M_W;
   localparam int DIGITS = (M_W + 7) / 8;
   localparam int CNT_W  = $clog2(DIGITS + 1);

   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   a_ff, a_in;
   logic [M_W-1:0]   b_ff, b_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = P_W'(a_mag);
         b_in    = b_mag;
         neg_in  = neg;
         cnt_in  = CNT_W'(DIGITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + P_W'(a_ff * b_ff[7:0]);
         a_in   = P_W'(a_ff << 8);
         b_in   = M_W'(b_ff >> 8);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign prod = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});

endmodule
`default_nettype wire

FILE: rtl/rsnh_sqrt.sv
// Restoring integer square root that settles one root bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsnh_sqrt #(
   parameter int H_W = 78,
   parameter int S_W = 39
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [H_W-1:0]  radicand,
   output logic                 done,
   output logic [S_W-1:0]       root
);
   import rsnh_pkg::*;

   localparam int CNT_W = $clog2(S_W + 1);

   logic [H_W-1:0]   x_ff, x_in;
   logic [S_W+1:0]   rem_ff, rem_in;
   logic [S_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [S_W+3:0]   rem_sh;
   logic [S_W+3:0]   trial;

   always_comb begin
      rem_sh  = {rem_ff, x_ff[H_W-1:H_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(S_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = H_W'(x_ff << 2);
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = (S_W+2)'(rem_sh - trial);
            root_in = {root_ff[S_W-2:0], 1'b1};
         end else begin
            rem_in  = (S_W+2)'(rem_sh);
            root_in = {root_ff[S_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

FILE: rtl/rsnh_back.sv
// Back end: sequences the sphere test, keeps the nearest hit and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module rsnh_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsnh_pkg::cfg_type   cfg,
   input  wire logic                q_valid,
   input  wire rsnh_pkg::entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit_found,
   output logic [31:0]              rsp_hit_id,
   output logic [30:0]              rsp_hit_distance
);
   import rsnh_pkg::*;

   localparam int DOT_W = 53;
   localparam int B_W   = 54 - FRAC_BITS;
   localparam int M_W   = (B_W > 33) ? B_W : 33;
   localparam int P_W   = 2 * M_W;
   localparam int H_W   = P_W + 2;
   localparam int S_W   = H_W / 2;
   localparam int T_W   = S_W + 2;

   state_type               state_ff, state_in;
   logic                    launch_ff;
   entry_type               cur_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic signed [H_W-1:0]   hacc_ff;
   logic [30:0]             best_dist_ff;
   logic [31:0]             best_id_ff;
   logic                    any_hit_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic [31:0]             rsp_id_ff;
   logic [30:0]             rsp_dist_ff;

   logic                    mul_start;
   logic [M_W-1:0]          mul_a;
   logic [M_W-1:0]          mul_b;
   logic                    mul_neg;
   logic                    mul_done;
   logic signed [P_W:0]     mul_prod;
   logic                    sqrt_start;
   logic                    sqrt_done;
   logic [S_W-1:0]          sqrt_root;

   logic signed [M_W:0]     ox_e, oy_e, oz_e;
   logic signed [M_W:0]     dx_e, dy_e, dz_e;
   logic signed [M_W:0]     b_e;
   logic [M_W-1:0]          ox_m, oy_m, oz_m, dx_m, dy_m, dz_m, b_m;
   logic signed [B_W-1:0]   b_s;
   logic signed [T_W-1:0]   b_t, s_t, t1, t2, t_sel;
   logic [30:0]             limit;
   logic                    hit_ok;
   logic                    out_free;
   logic                    emit;

   always_comb begin
      ox_e = (M_W+1)'(cur_ff.off_x);
      oy_e = (M_W+1)'(cur_ff.off_y);
      oz_e = (M_W+1)'(cur_ff.off_z);
      dx_e = (M_W+1)'(cfg.dir_x);
      dy_e = (M_W+1)'(cfg.dir_y);
      dz_e = (M_W+1)'(cfg.dir_z);
      b_s  = B_W'(dot_ff >>> FRAC_BITS);
      b_e  = (M_W+1)'(b_s);
      ox_m = ox_e[M_W] ? M_W'(-ox_e) : M_W'(ox_e);
      oy_m = oy_e[M_W] ? M_W'(-oy_e) : M_W'(oy_e);
      oz_m = oz_e[M_W] ? M_W'(-oz_e) : M_W'(oz_e);
      dx_m = dx_e[M_W] ? M_W'(-dx_e) : M_W'(dx_e);
      dy_m = dy_e[M_W] ? M_W'(-dy_e) : M_W'(dy_e);
      dz_m = dz_e[M_W] ? M_W'(-dz_e) : M_W'(dz_e);
      b_m  = b_e[M_W] ? M_W'(-b_e) : M_W'(b_e);
   end

   always_comb begin
      b_t   = T_W'(b_s);
      s_t   = $signed({{(T_W-S_W){1'b0}}, sqrt_root});
      t1    = -b_t - s_t;
      t2    = -b_t + s_t;
      t_sel = t1[T_W-1] ? t2 : t1;
      limit = any_hit_ff ? best_dist_ff : cfg.max_range;
      hit_ok = !hacc_ff[H_W-1] && !t_sel[T_W-1]
               && ($unsigned(t_sel) < T_W'(limit));
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == ST_FINISH) && cur_ff.last && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = q_entry.test ? ST_DOT_X : ST_FINISH;
            end
         end
         ST_DOT_X:  if (mul_done) state_in = ST_DOT_Y;
         ST_DOT_Y:  if (mul_done) state_in = ST_DOT_Z;
         ST_DOT_Z:  if (mul_done) state_in = ST_SQ_X;
         ST_SQ_X:   if (mul_done) state_in = ST_SQ_Y;
         ST_SQ_Y:   if (mul_done) state_in = ST_SQ_Z;
         ST_SQ_Z:   if (mul_done) state_in = ST_RAD_SQ;
         ST_RAD_SQ: if (mul_done) state_in = ST_B_SQ;
         ST_B_SQ:   if (mul_done) state_in = ST_ROOT;
         ST_ROOT:   if (sqrt_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!cur_ff.last || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      mul_start  = 1'b0;
      mul_a      = ox_m;
      mul_b      = dx_m;
      mul_neg    = ox_e[M_W] ^ dx_e[M_W];
      sqrt_start = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop = 1'b1;
         ST_DOT_X: begin
            mul_start = launch_ff;
         end
         ST_DOT_Y: begin
            mul_start = launch_ff;
            mul_a     = oy_m;
            mul_b     = dy_m;
            mul_neg   = oy_e[M_W] ^ dy_e[M_W];
         end
         ST_DOT_Z: begin
            mul_start = launch_ff;
            mul_a     = oz_m;
            mul_b     = dz_m;
            mul_neg   = oz_e[M_W] ^ dz_e[M_W];
         end
         ST_SQ_X: begin
            mul_start = launch_ff;
            mul_b     = ox_m;
            mul_neg   = 1'b0;
         end
         ST_SQ_Y: begin
            mul_start = launch_ff;
            mul_a     = oy_m;
            mul_b     = oy_m;
            mul_neg   = 1'b0;
         end
         ST_SQ_Z: begin
            mul_start = launch_ff;
            mul_a     = oz_m;
            mul_b     = oz_m;
            mul_neg   = 1'b0;
         end
         ST_RAD_SQ: begin
            mul_start = launch_ff;
            mul_a     = M_W'(cfg.sphere_radius);
            mul_b     = M_W'(cfg.sphere_radius);
            mul_neg   = 1'b0;
         end
         ST_B_SQ: begin
            mul_start = launch_ff;
            mul_a     = b_m;
            mul_b     = b_m;
            mul_neg   = 1'b0;
         end
         ST_ROOT: sqrt_start = launch_ff;
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         best_dist_ff <= MAX_RANGE_RESET;
         best_id_ff   <= '0;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_in != state_ff);
         if ((state_ff == ST_DECIDE) && hit_ok) begin
            best_dist_ff <= 31'(t_sel);
            best_id_ff   <= cur_ff.cand_id;
            any_hit_ff   <= 1'b1;
         end else if (emit) begin
            best_dist_ff <= cfg.max_range;
            best_id_ff   <= '0;
            any_hit_ff   <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && q_valid) begin
         cur_ff  <= q_entry;
         dot_ff  <= '0;
         hacc_ff <= '0;
      end else if (mul_done) begin
         case (state_ff)
            ST_DOT_X, ST_DOT_Y, ST_DOT_Z: dot_ff <= dot_ff + DOT_W'(mul_prod);
            ST_SQ_X, ST_SQ_Y, ST_SQ_Z:    hacc_ff <= hacc_ff - H_W'(mul_prod);
            ST_RAD_SQ, ST_B_SQ:           hacc_ff <= hacc_ff + H_W'(mul_prod);
            default:                      hacc_ff <= hacc_ff;
         endcase
      end
      if (emit) begin
         rsp_found_ff <= any_hit_ff;
         rsp_id_ff    <= any_hit_ff ? best_id_ff : '0;
         rsp_dist_ff  <= any_hit_ff ? best_dist_ff : '0;
      end
   end

   rsnh_mul #(.M_W(M_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_mag (mul_a),
      .b_mag (mul_b),
      .neg   (mul_neg),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rsnh_sqrt #(.H_W(H_W), .S_W(S_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (H_W'(hacc_ff)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_found    = rsp_found_ff;
   assign rsp_hit_id       = rsp_id_ff;
   assign rsp_hit_distance = rsp_dist_ff;

endmodule
`default_nettype wire

FILE: rtl/ray_sphere_nearest_hit.sv
// Top level of the ray-sphere nearest-hit block: configuration registers and units.
//
// Candidate centres arrive one per transaction on the req_ channel; the item
// marked last closes a list and produces exactly one transaction on rsp_ with
// the hit flag, the nearest id and its distance along the ray.
// The ray is to be set through the csr_ write port only while the block is idle; the block does not enforce this.
// The front end forms origin offsets and holds up to four candidates in a
// queue, so req_stall rises only when that queue is full.
// The back end tests one candidate at a time on a shared 8-bit-per-cycle
// multiplier (eight products) and a one-bit-per-cycle square root.
// The multiplier operand width is M = max(54 - FRAC_BITS, 33), and a candidate
// that is not remote skips the products and the square root.
// Results sit in an output register; while rsp_stall is high the result holds
// and the back end waits before closing another list, while the front end
// keeps accepting until its queue fills.
// Synchronous reset restores the register defaults, empties the queue and
// clears the running best and any pending result.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_nearest_hit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [31:0]                 req_center_x,
   input  wire logic signed [31:0]                 req_center_y,
   input  wire logic signed [31:0]                 req_center_z,
   input  wire logic [31:0]                        req_entity_id,
   input  wire logic                               req_is_remote,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit_found,
   output logic [31:0]                             rsp_hit_id,
   output logic [30:0]                             rsp_hit_distance,
   input  wire logic                               csr_we,
   input  wire logic [rsnh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rsnh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rsnh_pkg::*;

   cfg_type   cfg_ff;
   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.origin_z      <= '0;
         cfg_ff.dir_x         <= '0;
         cfg_ff.dir_y         <= '0;
         cfg_ff.dir_z         <= DIR_Z_RESET;
         cfg_ff.sphere_radius <= RADIUS_RESET;
         cfg_ff.max_range     <= MAX_RANGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:      cfg_ff.origin_x      <= csr_wdata;
            CSR_ORIGIN_Y:      cfg_ff.origin_y      <= csr_wdata;
            CSR_ORIGIN_Z:      cfg_ff.origin_z      <= csr_wdata;
            CSR_DIR_X:         cfg_ff.dir_x         <= csr_wdata[17:0];
            CSR_DIR_Y:         cfg_ff.dir_y         <= csr_wdata[17:0];
            CSR_DIR_Z:         cfg_ff.dir_z         <= csr_wdata[17:0];
            CSR_SPHERE_RADIUS: cfg_ff.sphere_radius <= csr_wdata[23:0];
            CSR_MAX_RANGE:     cfg_ff.max_range     <= csr_wdata[30:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   rsnh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_center_z  (req_center_z),
      .req_entity_id (req_entity_id),
      .req_is_remote (req_is_remote),
      .req_last      (req_last),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   rsnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_found    (rsp_hit_found),
      .rsp_hit_id       (rsp_hit_id),
      .rsp_hit_distance (rsp_hit_distance)
   );

endmodule
`default_nettype wire

FILE: rtl/rsnh_checker.sv
// Port-level checker for the ray-sphere nearest-hit block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rsnh_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_hit_found,
   input  wire logic [31:0] rsp_hit_id,
   input  wire logic [30:0] rsp_hit_distance
);
   import rsnh_pkg::*;

   logic [7:0] pending_ff, pending_in;
   logic       last_in_txn;
   logic       rsp_txn;

   assign last_in_txn = req_valid && !req_stall && req_last;
   assign rsp_txn     = rsp_valid && !rsp_stall;
   assign pending_in  = pending_ff + 8'(last_in_txn) - 8'(rsp_txn);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_found)
         && $stable(rsp_hit_id) && $stable(rsp_hit_distance))
      else $error("Stalled result changed.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_found |-> rsp_hit_id == 32'd0 && rsp_hit_distance == 31'd0)
      else $error("Miss result carries nonzero fields.");

   a_rsp_has_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("Result without a closed list.");

endmodule

bind ray_sphere_nearest_hit rsnh_checker u_rsnh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit_found    (rsp_hit_found),
   .rsp_hit_id       (rsp_hit_id),
   .rsp_hit_distance (rsp_hit_distance)
);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the ray-sphere nearest-hit block.
`timescale 1ns / 1ps
module tb_top;
   import rsnh_pkg::*;

   typedef struct {
      logic        found;
      logic [31:0] id;
      logic [30:0] distance;
   } hit_rec;

   typedef struct {
      logic [31:0] cx, cy, cz, eid;
      logic        remote, last_flag, typed;
      logic        found;
      logic [31:0] id;
      logic [30:0] distance;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [31:0] req_entity_id = '0;
   logic req_is_remote = 1'b0, req_last = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0, rsp_hit_found;
   logic [31:0] rsp_hit_id;
   logic [30:0] rsp_hit_distance;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ray_sphere_nearest_hit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cfg_type ray;
   longint best_dist;
   logic [31:0] best_id;
   logic any_hit;
   hit_rec pending_hits[$];
   int errors = 0, mismatches = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;

   function automatic logic [63:0] isqrt128(logic [127:0] x);
      logic [63:0] root, cand;
      logic [127:0] c128;
      root = '0;
      for (int bitpos = 63; bitpos >= 0; bitpos--) begin
         cand = root | (64'd1 << bitpos);
         c128 = {64'd0, cand};
         if (c128 * c128 <= x) root = cand;
      end
      return root;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_ORIGIN_X:      ray.origin_x = value;
         CSR_ORIGIN_Y:      ray.origin_y = value;
         CSR_ORIGIN_Z:      ray.origin_z = value;
         CSR_DIR_X:         ray.dir_x = value[17:0];
         CSR_DIR_Y:         ray.dir_y = value[17:0];
         CSR_DIR_Z:         ray.dir_z = value[17:0];
         CSR_SPHERE_RADIUS: ray.sphere_radius = value[23:0];
         CSR_MAX_RANGE:     ray.max_range = value[30:0];
         default: ;
      endcase
   endtask

   // Runs the nearest-hit update for one accepted candidate and returns 1 with
   // the list result when the candidate closes its list.
   function automatic bit predict_candidate(stim_row r, output hit_rec res);
      longint ox, oy, oz, b, t, limit;
      logic signed [127:0] wx, wy, wz, wb, wr, h;
      logic [63:0] s;
      if (r.remote) begin
         ox = longint'(ray.origin_x) - longint'($signed(r.cx));
         oy = longint'(ray.origin_y) - longint'($signed(r.cy));
         oz = longint'(ray.origin_z) - longint'($signed(r.cz));
         b = (ox * longint'(ray.dir_x) + oy * longint'(ray.dir_y)
              + oz * longint'(ray.dir_z)) >>> 16;
         wx = ox; wy = oy; wz = oz; wb = b;
         wr = longint'({8'd0, ray.sphere_radius});
         h = wb * wb - (wx * wx + wy * wy + wz * wz - wr * wr);
         if (h >= 0) begin
            s = isqrt128(h);
            t = -b - longint'(s);
            if (t < 0) t = -b + longint'(s);
            limit = any_hit ? best_dist : longint'({1'b0, ray.max_range});
            if (t >= 0 && t < limit) begin
               best_dist = t;
               best_id = r.eid;
               any_hit = 1'b1;
            end
         end
      end
      res.found = any_hit;
      res.id = any_hit ? best_id : '0;
      res.distance = any_hit ? best_dist[30:0] : '0;
      if (!r.last_flag) return 0;
      best_dist = longint'({1'b0, ray.max_range});
      best_id = '0;
      any_hit = 1'b0;
      return 1;
   endfunction

   task automatic send_candidate(stim_row r);
      hit_rec res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_center_x = r.cx;
      req_center_y = r.cy;
      req_center_z = r.cz;
      req_entity_id = r.eid;
      req_is_remote = r.remote;
      req_last = r.last_flag;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      if (predict_candidate(r, res)) begin
         if (r.typed) begin
            res.found = r.found;
            res.id = r.id;
            res.distance = r.distance;
         end
         pending_hits = {pending_hits, res};
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_hits.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic random_lists(int count);
      stim_row r;
      longint tpick, noise, rad;
      int n;
      n = 0;
      while (n < count) begin
         int len;
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            r = '{default: '0};
            r.eid = $urandom;
            r.remote = ($urandom_range(99) < 85);
            r.last_flag = (k == len - 1);
            if ($urandom_range(99) < 75) begin
               tpick = $urandom_range(0, 300 << 16);
               rad = longint'(ray.sphere_radius);
               noise = longint'($urandom_range(0, 2 * rad + 2)) - rad - 1;
               r.cx = ray.origin_x + ((longint'(ray.dir_x) * tpick) >>> 16) + noise;
               r.cy = ray.origin_y + ((longint'(ray.dir_y) * tpick) >>> 16);
               r.cz = ray.origin_z + ((longint'(ray.dir_z) * tpick) >>> 16) - noise;
            end else begin
               r.cx = $urandom;
               r.cy = $urandom;
               r.cz = $urandom;
            end
            send_candidate(r);
            n++;
         end
      end
   endtask

   always @(negedge clock)
      rsp_stall = ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      hit_rec want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("Unexpected transaction on rsp_ at %0t", $realtime);
         end else begin
            want = pending_hits.pop_front();
            if (want.found !== rsp_hit_found || want.id !== rsp_hit_id
                || want.distance !== rsp_hit_distance) begin
               errors++;
               if (mismatches++ < 10)
                  $display("Mismatch: expected found %0b id %h dist %0d, got %0b %h %0d",
                           want.found, want.id, want.distance,
                           rsp_hit_found, rsp_hit_id, rsp_hit_distance);
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      stim_row rows[$];
      ray = '{origin_x: '0, origin_y: '0, origin_z: '0, dir_x: '0, dir_y: '0,
              dir_z: DIR_Z_RESET, sphere_radius: RADIUS_RESET, max_range: MAX_RANGE_RESET};
      best_dist = longint'({1'b0, MAX_RANGE_RESET});
      best_id = '0;
      any_hit = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rows = '{
         '{0, 0, 655360, 5, 1, 1, 1, 1, 5, 653394},
         '{0, 0, 655360, 6, 0, 1, 1, 0, 0, 0},
         '{0, 0, -655360, 3, 1, 1, 1, 0, 0, 0},
         '{0, 0, 655360, 7, 1, 0, 0, 0, 0, 0},
         '{0, 0, 655360, 8, 1, 1, 1, 1, 7, 653394},
         '{0, 0, 655360, 1, 1, 0, 0, 0, 0, 0},
         '{0, 0, 131072, 2, 1, 1, 1, 1, 2, 129106},
         '{0, 0, 7000000, 4, 1, 1, 1, 0, 0, 0},
         '{0, 0, 655360, 9, 1, 0, 0, 0, 0, 0},
         '{0, 0, 0, 10, 0, 1, 1, 1, 9, 653394},
         '{32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff, 1, 0, 0, 0, 0, 0},
         '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1, 1, 0, 0, 0, 0},
         '{1000, -1000, 3 << 16, 32'h5a5a5a5a, 1, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'ha5a5a5a5, 1, 1, 0, 0, 0, 0},
         '{2000, 0, 6553600, 11, 1, 1, 0, 0, 0, 0}
      };
      foreach (rows[i]) send_candidate(rows[i]);
      drain();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         case (phase)
            2: begin
               write_reg(CSR_ORIGIN_X, 32'h80000000);
               write_reg(CSR_ORIGIN_Y, 32'h7fffffff);
               write_reg(CSR_ORIGIN_Z, 32'h00000000);
               write_reg(CSR_DIR_X, 32'h30000);
               write_reg(CSR_DIR_Y, 32'h10000);
               write_reg(CSR_DIR_Z, 32'h20000);
               write_reg(CSR_SPHERE_RADIUS, 32'hffffff);
               write_reg(CSR_MAX_RANGE, 32'h7fffffff);
            end
            5: begin
               write_reg(CSR_SPHERE_RADIUS, 32'h0);
               write_reg(CSR_MAX_RANGE, 32'h0);
            end
            7: begin
               for (int idx = 0; idx < 8; idx++)
                  write_reg(CSR_IDX_W'(idx), $urandom);
            end
            default: begin
               write_reg(CSR_ORIGIN_X, $urandom_range(0, 2000 << 16) - (1000 << 16));
               write_reg(CSR_ORIGIN_Y, $urandom_range(0, 2000 << 16) - (1000 << 16));
               write_reg(CSR_ORIGIN_Z, $urandom_range(0, 2000 << 16) - (1000 << 16));
               write_reg(CSR_DIR_X, $urandom_range(0, 131072) - 65536);
               write_reg(CSR_DIR_Y, $urandom_range(0, 131072) - 65536);
               write_reg(CSR_DIR_Z, $urandom_range(0, 131072) - 65536);
               write_reg(CSR_SPHERE_RADIUS, $urandom_range(0, 5 << 16));
               write_reg(CSR_MAX_RANGE, $urandom_range(0, 400 << 16));
            end
         endcase
         best_dist = longint'({1'b0, ray.max_range});
         random_lists(100);
         drain();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
